### rtl/glyph_lookup_rasterizer_top_macros.svh
`ifndef GLYPH_LOOKUP_RASTERIZER_TOP_MACROS_SVH
`define GLYPH_LOOKUP_RASTERIZER_TOP_MACROS_SVH

// assertion helpers, clocked on clk and off while rst_n is low

// condition holds at every edge
`define GLR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define GLR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/glr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package glr_pkg;

  // default sizes
  localparam int DEF_TABLE_ENTRIES = 256;
  localparam int DEF_GLYPH_ROWS    = 16;

  // field widths
  localparam int FUNC_W    = 2;
  localparam int ENTRY_W   = 8;
  localparam int SLOT_W    = 5;
  localparam int CODE_W    = 21;
  localparam int COORD_W   = 12;
  localparam int ROWY_W    = 13;
  localparam int MASK_W    = 9;
  localparam int COLOR_W   = 24;
  localparam int COUNT_W   = 9;
  localparam int DFLT_W    = 8;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;

  // bitmap layout of one entry
  localparam int BYTES_PER_ENTRY = 18;
  localparam int SLOT_NINE_A     = 16;
  localparam int SLOT_NINE_B     = 17;

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  localparam code_t MAX_CODE_RESET = 21'h10FFFF;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_WR_CODE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_BYTE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DRAW    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CODE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_INDEX = 2'd3;

endpackage

`default_nettype wire

### rtl/glr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface glr_in_if;
  import glr_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ENTRY_W-1:0]  entry_index;
  logic [SLOT_W-1:0]   byte_slot;
  logic [CODE_W-1:0]   write_value;
  logic [CODE_W-1:0]   draw_code;
  logic [COORD_W-1:0]  origin_x;
  logic [COORD_W-1:0]  origin_y;
  logic [COLOR_W-1:0]  ink_color;

  modport source (
    output valid, func, entry_index, byte_slot, write_value, draw_code,
           origin_x, origin_y, ink_color,
    input  ready
  );

  modport sink (
    input  valid, func, entry_index, byte_slot, write_value, draw_code,
           origin_x, origin_y, ink_color,
    output ready
  );
endinterface

`default_nettype wire

### rtl/glr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface glr_out_if;
  import glr_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] row_x;
  logic [ROWY_W-1:0]  row_y;
  logic [MASK_W-1:0]  pixel_mask;
  logic [COLOR_W-1:0] row_color;
  logic               last_row;

  modport source (
    output valid, row_x, row_y, pixel_mask, row_color, last_row,
    input  ready
  );

  modport sink (
    input  valid, row_x, row_y, pixel_mask, row_color, last_row,
    output ready
  );
endinterface

`default_nettype wire

### rtl/glyph_lookup_rasterizer_top.sv
// glyph lookup rasterizer: 9-pixel-wide bitmap font character generator
//
// in_ch  : one item per transfer. func selects a code point write, a bitmap
//          byte write or a character draw. writes land in the glyph table
//          in the cycle of the transfer and give no result.
// out_ch : a draw gives GLYPH_ROWS row transfers (mask msb = leftmost pixel),
//          last_row marks the final one.
// cfg_*  : register write port (min_code, max_code, glyph_count,
//          default_index); write only while no draw is in flight.
// steps  : default_index is first reduced modulo TABLE_ENTRIES by repeated
//          subtraction in ST_DMOD (needed only when the table is smaller
//          than 256). the code point search reads the code memory one
//          entry per cycle, up to glyph_count entries. the two ninth-column
//          bytes are read next, then one row per cycle from the bitmap
//          memory while the receiver does not stall.
// stall  : rows sit in an output register; a stalled receiver freezes the row
//          fetch. in_ch takes the next item once the last row is loaded.
// reset  : rst_n (sync, active low) resets control and registers; the glyph
//          table memories are not cleared and must be written before use.
`timescale 1ns / 1ps
`default_nettype none

module glyph_lookup_rasterizer_top #(
  parameter int TABLE_ENTRIES = glr_pkg::DEF_TABLE_ENTRIES,
  parameter int GLYPH_ROWS    = glr_pkg::DEF_GLYPH_ROWS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  glr_in_if.sink                         in_ch,
  glr_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [glr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [glr_pkg::CODE_W-1:0]     cfg_wdata
);
  import glr_pkg::*;

`include "glyph_lookup_rasterizer_top_macros.svh"

  localparam int IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
  localparam int BM_DEPTH = TABLE_ENTRIES * BYTES_PER_ENTRY;
  localparam int BA_W     = $clog2(BM_DEPTH);
  localparam int ROW_W    = $clog2(GLYPH_ROWS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DMOD,
    ST_SEARCH,
    ST_NINE_A,
    ST_NINE_B,
    ST_NINE_C,
    ST_ROWS
  } state_t;

  // configuration registers
  code_t              min_code_r;
  code_t              max_code_r;
  logic [COUNT_W-1:0] glyph_count_r;
  logic [DFLT_W-1:0]  default_index_r;

  // sequencer state
  state_t             state_r,   state_nxt;
  code_t              code_r,    code_nxt;
  coord_t             ox_r,      ox_nxt;
  coord_t             oy_r,      oy_nxt;
  color_t             ink_r,     ink_nxt;
  logic               oor_r,     oor_nxt;
  logic [DFLT_W-1:0]  dflt_r,    dflt_nxt;
  logic [CNT_W-1:0]   idx_r,     idx_nxt;
  logic               pend_r,    pend_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [BA_W-1:0]    base_r,    base_nxt;
  byte_t              nine_a_r,  nine_a_nxt;
  byte_t              nine_b_r,  nine_b_nxt;
  logic [ROW_W-1:0]   row_r,     row_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  coord_t             row_x_r,     row_x_nxt;
  logic [ROWY_W-1:0]  row_y_r,     row_y_nxt;
  logic [MASK_W-1:0]  mask_r,      mask_nxt;
  color_t             color_r,     color_nxt;
  logic               last_row_r,  last_row_nxt;

  // memory ports
  logic               code_we;
  logic               code_re;
  logic [IDX_W-1:0]   code_raddr;
  code_t              code_rdata;
  logic               bm_we;
  logic [BA_W-1:0]    bm_waddr;
  logic               bm_re;
  logic [BA_W-1:0]    bm_raddr;
  byte_t              bm_rdata;

  logic               in_xfer;
  logic               entry_ok;
  logic               slot_ok;
  logic               can_issue;
  logic [3:0]         row_ext;
  logic [2:0]         bit_sel;
  logic               ninth;
  logic [ROW_W-1:0]   row_inc;
  logic               row_last;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // table writes go straight to the memories
  assign entry_ok = 32'(in_ch.entry_index) < TABLE_ENTRIES;
  assign slot_ok  = in_ch.byte_slot < SLOT_W'(BYTES_PER_ENTRY);
  assign code_we  = in_xfer && (in_ch.func == FUNC_WR_CODE) && entry_ok;
  assign bm_we    = in_xfer && (in_ch.func == FUNC_WR_BYTE) && entry_ok && slot_ok;
  assign bm_waddr = BA_W'(in_ch.entry_index) * BA_W'(BYTES_PER_ENTRY)
                    + BA_W'(in_ch.byte_slot);

  // search stops at glyph_count or at the end of the table
  assign can_issue = (32'(idx_r) < 32'(glyph_count_r)) && (32'(idx_r) < TABLE_ENTRIES);

  // ninth column: byte 16 for rows 0-7, byte 17 for rows 8-15, msb first
  assign row_ext  = 4'(row_r);
  assign bit_sel  = 3'd7 - row_ext[2:0];
  assign ninth    = row_ext[3] ? nine_b_r[bit_sel] : nine_a_r[bit_sel];
  assign row_inc  = row_r + 1'b1;
  assign row_last = (row_r == ROW_W'(GLYPH_ROWS - 1));

  glr_ram #(
    .WIDTH (CODE_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_code_ram (
    .clk   (clk),
    .we    (code_we),
    .waddr (IDX_W'(in_ch.entry_index)),
    .wdata (in_ch.write_value),
    .re    (code_re),
    .raddr (code_raddr),
    .rdata (code_rdata)
  );

  glr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BM_DEPTH)
  ) u_bitmap_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (in_ch.write_value[BYTE_W-1:0]),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    ink_nxt       = ink_r;
    oor_nxt       = oor_r;
    dflt_nxt      = dflt_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    base_nxt      = base_r;
    nine_a_nxt    = nine_a_r;
    nine_b_nxt    = nine_b_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    row_x_nxt     = row_x_r;
    row_y_nxt     = row_y_r;
    mask_nxt      = mask_r;
    color_nxt     = color_r;
    last_row_nxt  = last_row_r;
    code_re       = 1'b0;
    code_raddr    = idx_r[IDX_W-1:0];
    bm_re         = 1'b0;
    bm_raddr      = base_r + BA_W'(SLOT_NINE_A);

    // row leaves the output register
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_ch.func == FUNC_DRAW)) begin
          code_nxt  = in_ch.draw_code;
          ox_nxt    = in_ch.origin_x;
          oy_nxt    = in_ch.origin_y;
          ink_nxt   = in_ch.ink_color;
          oor_nxt   = (in_ch.draw_code < min_code_r) || (in_ch.draw_code > max_code_r);
          dflt_nxt  = default_index_r;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_DMOD;
        end
      end

      // default_index modulo table size
      ST_DMOD: begin
        if (32'(dflt_r) >= TABLE_ENTRIES) begin
          dflt_nxt = dflt_r - DFLT_W'(TABLE_ENTRIES);
        end else if (oor_r) begin
          base_nxt  = BA_W'(dflt_r) * BA_W'(BYTES_PER_ENTRY);
          state_nxt = ST_NINE_A;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end

      // one code read issued per cycle, compared the cycle after
      ST_SEARCH: begin
        if (pend_r && (code_rdata == code_r)) begin
          base_nxt  = BA_W'(pend_idx_r) * BA_W'(BYTES_PER_ENTRY);
          pend_nxt  = 1'b0;
          state_nxt = ST_NINE_A;
        end else if ((pend_r && (code_rdata > code_r)) || (!pend_r && !can_issue)) begin
          base_nxt  = BA_W'(dflt_r) * BA_W'(BYTES_PER_ENTRY);
          pend_nxt  = 1'b0;
          state_nxt = ST_NINE_A;
        end else if (can_issue) begin
          code_re      = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt      = idx_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end

      ST_NINE_A: begin
        bm_re     = 1'b1;
        bm_raddr  = base_r + BA_W'(SLOT_NINE_A);
        state_nxt = ST_NINE_B;
      end

      ST_NINE_B: begin
        nine_a_nxt = bm_rdata;
        bm_re      = 1'b1;
        bm_raddr   = base_r + BA_W'(SLOT_NINE_B);
        state_nxt  = ST_NINE_C;
      end

      ST_NINE_C: begin
        nine_b_nxt = bm_rdata;
        row_nxt    = '0;
        bm_re      = 1'b1;
        bm_raddr   = base_r;
        state_nxt  = ST_ROWS;
      end

      // row byte is in bm_rdata; load it and fetch the next row
      ST_ROWS: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          row_x_nxt     = ox_r;
          row_y_nxt     = ROWY_W'(oy_r) + ROWY_W'(row_r);
          mask_nxt      = {bm_rdata, ninth};
          color_nxt     = ink_r;
          last_row_nxt  = row_last;
          if (row_last) begin
            state_nxt = ST_IDLE;
          end else begin
            row_nxt  = row_inc;
            bm_re    = 1'b1;
            bm_raddr = base_r + BA_W'(row_inc);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      pend_r          <= 1'b0;
      idx_r           <= '0;
      out_valid_r     <= 1'b0;
      min_code_r      <= '0;
      max_code_r      <= MAX_CODE_RESET;
      glyph_count_r   <= '0;
      default_index_r <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_CODE:      min_code_r      <= cfg_wdata;
          CFG_MAX_CODE:      max_code_r      <= cfg_wdata;
          CFG_GLYPH_COUNT:   glyph_count_r   <= cfg_wdata[COUNT_W-1:0];
          CFG_DEFAULT_INDEX: default_index_r <= cfg_wdata[DFLT_W-1:0];
        endcase
      end
    end
    code_r     <= code_nxt;
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
    ink_r      <= ink_nxt;
    oor_r      <= oor_nxt;
    dflt_r     <= dflt_nxt;
    pend_idx_r <= pend_idx_nxt;
    base_r     <= base_nxt;
    nine_a_r   <= nine_a_nxt;
    nine_b_r   <= nine_b_nxt;
    row_r      <= row_nxt;
    row_x_r    <= row_x_nxt;
    row_y_r    <= row_y_nxt;
    mask_r     <= mask_nxt;
    color_r    <= color_nxt;
    last_row_r <= last_row_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.row_x      = row_x_r;
  assign out_ch.row_y      = row_y_r;
  assign out_ch.pixel_mask = mask_r;
  assign out_ch.row_color  = color_r;
  assign out_ch.last_row   = last_row_r;

  // a pending code read only exists while searching
  `GLR_ASSERT_IMPLY(a_pend_in_search, pend_r, state_r == ST_SEARCH, "code read pending outside search")
  // scan index never runs past the table
  `GLR_ASSERT_ALWAYS(a_idx_bound, 32'(idx_r) <= TABLE_ENTRIES, "search index past table end")
  // fallback entry is reduced before it can be chosen
  `GLR_ASSERT_IMPLY(a_dflt_reduced, state_r == ST_SEARCH || state_r == ST_NINE_A, 32'(dflt_r) < TABLE_ENTRIES, "default entry not reduced")
  // a non-final row on the output means the glyph is still being emitted
  `GLR_ASSERT_IMPLY(a_rows_pending, out_valid_r && !last_row_r, state_r == ST_ROWS, "left row emission before last row")

endmodule

`default_nettype wire

### rtl/glr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module glr_ram #(
  parameter int WIDTH = glr_pkg::BYTE_W,
  parameter int DEPTH = glr_pkg::DEF_TABLE_ENTRIES,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
